FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/rmsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsu_pkg
// Shared widths and sideband type of the range mean and spread unit.
// ----------------------------------------------------------------------------
package rmsu_pkg;

	localparam int CNT_W      = 20;
	localparam int SUM_W      = 48;
	localparam int SQ_W       = 63;
	localparam int OFF_W      = 32;
	localparam int SPREAD_W   = 64;
	localparam int ROOT_W     = 32;
	localparam int ROOT_REM_W = 33;
	localparam int MEAN_STEPS = 48;
	localparam int ROOT_STEPS = 32;
	localparam int DEV_STEPS  = 32;
	localparam int CHAIN_LEN  = ROOT_STEPS + DEV_STEPS;

	// control and pass-through data that rides alongside each row
	typedef struct packed {
		logic             vld;
		logic [7:0]       id;
		logic             rv;
		logic             neg;
		logic [CNT_W-1:0] cnt;
		logic [OFF_W-1:0] off;
	} side_t;

endpackage
`default_nettype wire

FILE: rtl/core/rmsu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsu_front
// Four-stage front end: magnitude of the sum, split products, spread.
// ----------------------------------------------------------------------------
module rmsu_front import rmsu_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_i,
	input  wire logic [7:0]          peer_id,
	input  wire logic [CNT_W-1:0]    sample_count,
	input  wire logic [SUM_W-1:0]    range_sum,
	input  wire logic [SQ_W-1:0]     range_square_sum,
	input  wire logic [OFF_W-1:0]    range_offset,
	output side_t                    side_o,
	output logic      [SUM_W-1:0]    mag_o,
	output logic      [SPREAD_W-1:0] spread_o
);

	side_t side_s1, side_s2, side_s3;
	logic [SUM_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [SQ_W-1:0]  sq_s1;
	logic [51:0] pa0_s2;
	logic [50:0] pa1_s2;
	logic [47:0] pll_s2, plh_s2, phh_s2;
	logic [82:0] a_s3;
	logic [95:0] b_s3;
	logic [95:0] diff;
	logic        gt;

	assign gt   = {13'b0, a_s3} > b_s3;
	assign diff = {13'b0, a_s3} - b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_o  <= '0;
		end else if (en) begin
			side_s1.vld <= vld_i;
			side_s1.id  <= peer_id;
			side_s1.rv  <= (peer_id != 8'd0) && (sample_count != '0);
			side_s1.neg <= range_sum[SUM_W-1];
			side_s1.cnt <= sample_count;
			side_s1.off <= range_offset;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_o  <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// |sum| fits 48 bits unsigned, including the most negative sum
			mag_s1 <= range_sum[SUM_W-1] ? (SUM_W'(0) - range_sum) : range_sum;
			sq_s1  <= range_square_sum;
			// products no wider than 32x32
			pa0_s2 <= side_s1.cnt * sq_s1[31:0];
			pa1_s2 <= side_s1.cnt * sq_s1[62:32];
			pll_s2 <= mag_s1[23:0] * mag_s1[23:0];
			plh_s2 <= mag_s1[23:0] * mag_s1[47:24];
			phh_s2 <= mag_s1[47:24] * mag_s1[47:24];
			mag_s2 <= mag_s1;
			a_s3 <= {31'b0, pa0_s2} + {pa1_s2, 32'b0};
			b_s3 <= {48'b0, pll_s2} + {23'b0, plh_s2, 25'b0} + {phh_s2, 48'b0};
			mag_s3 <= mag_s2;
			mag_o  <= mag_s3;
			if (!gt)
				spread_o <= '0;
			else if (|diff[95:64])
				spread_o <= '1;
			else
				spread_o <= diff[63:0];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rmsu_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsu_div_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module rmsu_div_cell import rmsu_pkg::*; #(
	parameter int W = MEAN_STEPS
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [CNT_W-1:0] cnt,
	input  wire logic [CNT_W-1:0] rem_i,
	input  wire logic [W-1:0]     num_i,
	output logic      [CNT_W-1:0] rem_o,
	output logic      [W-1:0]     num_o
);

	logic [CNT_W:0] trial, diff;
	logic           ge;

	assign trial = {rem_i, num_i[W-1]};
	assign ge    = trial >= {1'b0, cnt};
	assign diff  = trial - {1'b0, cnt};

	// dividend bits shift out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			num_o <= {num_i[W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rmsu_root_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsu_root_cell
// One digit of the floor square root: two operand bits per cell.
// ----------------------------------------------------------------------------
module rmsu_root_cell import rmsu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [SPREAD_W-1:0]   x_i,
	input  wire logic [ROOT_REM_W-1:0] rem_i,
	input  wire logic [ROOT_W-1:0]     root_i,
	output logic      [SPREAD_W-1:0]   x_o,
	output logic      [ROOT_REM_W-1:0] rem_o,
	output logic      [ROOT_W-1:0]     root_o
);

	logic [ROOT_REM_W+1:0] cur, trial, diff;
	logic                  ge;

	assign cur   = {rem_i, x_i[SPREAD_W-1 -: 2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign ge    = cur >= trial;
	assign diff  = cur - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			x_o    <= {x_i[SPREAD_W-3:0], 2'b00};
			rem_o  <= ge ? diff[ROOT_REM_W-1:0] : cur[ROOT_REM_W-1:0];
			root_o <= {root_i[ROOT_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/range_mean_and_spread_unit.sv
// A result follows an input transfer through the 4 front stages, the 64 cells
// and 1 output register. Throughput: one row per cycle while not stalled.
// The whole pipeline advances together whenever the output register is
// empty or is being taken; a held result stalls the input.
// Reset (arst_n, async, active low) clears the sideband and the result valid.
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// range_mean_and_spread_unit
// Mean and standard deviation of a link's range statistics.
// ----------------------------------------------------------------------------
module range_mean_and_spread_unit import rmsu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic [7:0]       peer_id,
	input  wire logic [CNT_W-1:0] sample_count,
	input  wire logic [SUM_W-1:0] range_sum,
	input  wire logic [SQ_W-1:0]  range_square_sum,
	input  wire logic [OFF_W-1:0] range_offset,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic [7:0]            peer_out,
	output logic                  row_valid,
	output logic [31:0]           mean_range,
	output logic [31:0]           deviation
);

	localparam logic signed [49:0] MEAN_MAX = 50'sd2147483647;
	localparam logic signed [49:0] MEAN_MIN = -50'sd2147483648;

	// global advance: output register free or draining this cycle
	logic en;
	assign en         = !result_valid || !result_stall;
	assign item_stall = !en;

	// sideband and datapath per chain position (index 0 = front output)
	side_t               side_q [0:CHAIN_LEN];
	logic [SUM_W-1:0]    mnum   [0:CHAIN_LEN];
	logic [CNT_W-1:0]    mrem   [0:MEAN_STEPS];
	logic [SPREAD_W-1:0] rx     [0:ROOT_STEPS];
	logic [ROOT_REM_W-1:0] rrem [0:ROOT_STEPS];
	logic [ROOT_W-1:0]   rroot  [0:ROOT_STEPS];
	logic [CNT_W-1:0]    drem   [0:DEV_STEPS];
	logic [ROOT_W-1:0]   dnum   [0:DEV_STEPS];
	logic [SPREAD_W-1:0] spread;

	rmsu_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.vld_i            (item_valid),
		.peer_id          (peer_id),
		.sample_count     (sample_count),
		.range_sum        (range_sum),
		.range_square_sum (range_square_sum),
		.range_offset     (range_offset),
		.side_o           (side_q[0]),
		.mag_o            (mnum[0]),
		.spread_o         (spread)
	);

	assign mrem[0]  = '0;
	assign rx[0]    = spread;
	assign rrem[0]  = '0;
	assign rroot[0] = '0;
	assign drem[0]  = '0;
	assign dnum[0]  = rroot[ROOT_STEPS];

	genvar k;
	generate
		for (k = 0; k < CHAIN_LEN; k++) begin : g_chain
			// row sideband moves one cell per cycle while en is high
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					side_q[k+1] <= '0;
				else if (en)
					side_q[k+1] <= side_q[k];
			end

			// mean quotient: |sum| / count, then carried to the end
			if (k < MEAN_STEPS) begin : g_mean
				rmsu_div_cell #(.W(SUM_W)) u_mean (
					.clk   (clk),
					.en    (en),
					.cnt   (side_q[k].cnt),
					.rem_i (mrem[k]),
					.num_i (mnum[k]),
					.rem_o (mrem[k+1]),
					.num_o (mnum[k+1])
				);
			end else begin : g_mean_hold
				always_ff @(posedge clk) begin
					if (en)
						mnum[k+1] <= mnum[k];
				end
			end

			// first half: root digits; second half: root / count
			if (k < ROOT_STEPS) begin : g_root
				rmsu_root_cell u_root (
					.clk    (clk),
					.en     (en),
					.x_i    (rx[k]),
					.rem_i  (rrem[k]),
					.root_i (rroot[k]),
					.x_o    (rx[k+1]),
					.rem_o  (rrem[k+1]),
					.root_o (rroot[k+1])
				);
			end else begin : g_dev
				rmsu_div_cell #(.W(ROOT_W)) u_dev (
					.clk   (clk),
					.en    (en),
					.cnt   (side_q[k].cnt),
					.rem_i (drem[k-ROOT_STEPS]),
					.num_i (dnum[k-ROOT_STEPS]),
					.rem_o (drem[k-ROOT_STEPS+1]),
					.num_o (dnum[k-ROOT_STEPS+1])
				);
			end
		end
	endgenerate

	// mean finish: sign, offset, saturation
	side_t              side_end;
	logic [48:0]        qsigned;
	logic signed [49:0] msum;
	logic [31:0]        mean_sat;

	assign side_end = side_q[CHAIN_LEN];
	assign qsigned  = side_end.neg ? (49'd0 - {1'b0, mnum[CHAIN_LEN]})
	                               : {1'b0, mnum[CHAIN_LEN]};
	assign msum     = $signed({{18{side_end.off[31]}}, side_end.off})
	                + $signed({qsigned[48], qsigned});

	always_comb begin
		priority if (msum > MEAN_MAX)
			mean_sat = MEAN_MAX[31:0];
		else if (msum < MEAN_MIN)
			mean_sat = MEAN_MIN[31:0];
		else
			mean_sat = msum[31:0];
	end

	logic        result_valid_q;
	logic [7:0]  peer_q;
	logic        row_valid_q;
	logic [31:0] mean_q;
	logic [31:0] dev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (en)
			result_valid_q <= side_end.vld;
	end

	// invalid rows report zero mean and deviation, id still passes
	always_ff @(posedge clk) begin
		if (en) begin
			peer_q      <= side_end.id;
			row_valid_q <= side_end.rv;
			mean_q      <= side_end.rv ? mean_sat : 32'd0;
			dev_q       <= side_end.rv ? dnum[DEV_STEPS] : 32'd0;
		end
	end

	assign result_valid = result_valid_q;
	assign peer_out     = peer_q;
	assign row_valid    = row_valid_q;
	assign mean_range   = mean_q;
	assign deviation    = dev_q;

	`ASSERT_RST(a_accept_enters_front, (item_valid && !item_stall) |=> u_front.side_s1.vld, "accepted transfer did not enter the front stage")
	`ASSERT_RST(a_invalid_row_zero, (result_valid && !row_valid) |-> (mean_range == 32'd0 && deviation == 32'd0), "invalid row carries nonzero result")
	`ASSERT_RST(a_valid_row_has_id, (result_valid && row_valid) |-> (peer_out != 8'd0), "valid row with zero peer id")
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result_valid, "result valid during reset")

endmodule
`default_nettype wire
